// ===== rtl/hough_line_vote_accumulator_top_macros.svh =====
// Assertion macros for the Hough line vote accumulator.
// Used by the top level; no other dependencies.
`ifndef HOUGH_LINE_VOTE_ACCUMULATOR_TOP_MACROS_SVH
`define HOUGH_LINE_VOTE_ACCUMULATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define HLVA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define HLVA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HLVA_ASSERT_NOW(lbl, ante, cons, msg)
`define HLVA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/hlva_pkg.sv =====
// Package for the Hough line vote accumulator: constants, codes, types, trig table.
// No dependencies.
package hlva_pkg;

   localparam int MAX_DIM  = 512;
   localparam int RHO_ROWS = 2048;
   localparam int ANGLES   = 180;
   localparam int QUARTER  = 90;
   localparam int Q_FRAC   = 14;
   localparam int ROW_W    = $clog2(RHO_ROWS);
   localparam int ANG_W    = 8;
   localparam int CNT_W    = 8;
   localparam int OFS_W    = 10;
   localparam int CSR_IW   = 4;
   localparam int CSR_DW   = 10;
   localparam logic [CNT_W-1:0] CNT_MAX       = 8'd255;
   localparam logic [CNT_W-1:0] THRESHOLD_RST = 8'd200;
   localparam logic [OFS_W-1:0] OFFSET_RST    = 10'd724;
   localparam logic [CSR_IW-1:0] CSR_THRESHOLD = 4'd0;
   localparam logic [CSR_IW-1:0] CSR_OFFSET    = 4'd1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_VOTE  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             is_read;
      logic [8:0]       x;
      logic [8:0]       y;
      logic [10:0]      rho_idx;
      logic [7:0]       angle;
      logic [CNT_W-1:0] count;
      logic             found;
   } tok_type;

   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] data;
   } rd_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr;
   } clr_type;

   localparam logic [14:0] SIN_TAB [91] = '{
      15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
      15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240,
      15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402,
      15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438,
      15'd8682, 15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311,
      15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786,
      15'd11982, 15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
      15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
      15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082,
      15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
      15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182,
      15'd16225, 15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374,
      15'd16382, 15'd16384
   };

   // cos(t-90) = sin(t)
   function automatic logic signed [15:0] cos_term(input logic [ANG_W-1:0] t);
      logic [ANG_W-1:0] k;
      k = (t <= ANG_W'(QUARTER)) ? t : ANG_W'(ANGLES) - t;
      return $signed({1'b0, SIN_TAB[k[6:0]]});
   endfunction

   // sin(t-90) = -cos(t)
   function automatic logic signed [15:0] sin_term(input logic [ANG_W-1:0] t);
      logic [ANG_W-1:0] k;
      logic signed [15:0] v;
      k = (t <= ANG_W'(QUARTER)) ? ANG_W'(QUARTER) - t : t - ANG_W'(QUARTER);
      v = $signed({1'b0, SIN_TAB[k[6:0]]});
      return (t <= ANG_W'(QUARTER)) ? -v : v;
   endfunction

endpackage

// ===== rtl/hlva_if.sv =====
// Handshake channel interfaces for the Hough line vote accumulator.
// Depends on hlva_pkg.
interface hlva_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [8:0]  pixel_row;
   logic [8:0]  pixel_col;
   logic [10:0] rho_index;
   logic [7:0]  angle_index;
   modport source (output valid, opcode, pixel_row, pixel_col, rho_index, angle_index,
                   input ready);
   modport sink (input valid, opcode, pixel_row, pixel_col, rho_index, angle_index,
                 output ready);
endinterface

interface hlva_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] vote_count;
   logic       is_line;
   modport source (output valid, vote_count, is_line, input ready);
   modport sink (input valid, vote_count, is_line, output ready);
endinterface

interface hlva_csr_if;
   logic                          valid;
   logic                          ready;
   logic [hlva_pkg::CSR_IW-1:0]   index;
   logic [hlva_pkg::CSR_DW-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/hlva_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/hlva_cell.sv =====
// One angle column of the accumulator: rho compute, read-modify-write of its own RAM.
// Depends on hlva_pkg and hlva_ram.
module hlva_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hlva_pkg::ANG_W-1:0]    cell_idx,
   input  logic [hlva_pkg::OFS_W-1:0]    rho_offset,
   input  hlva_pkg::clr_type             clr,
   input  hlva_pkg::tok_type             tok_in,
   input  hlva_pkg::rd_type              rd_in,
   output hlva_pkg::tok_type             tok_out,
   output hlva_pkg::rd_type              rd_out
);
   hlva_pkg::tok_type tok_ff;
   logic signed [15:0] cos_c;
   logic signed [15:0] sin_c;
   logic signed [25:0] prod_y;
   logic signed [25:0] prod_x;
   logic signed [25:0] acc;
   logic signed [11:0] rho;
   logic signed [12:0] row;
   logic row_ok;
   logic in_img;
   logic vote_go;
   logic rd_go;
   logic [hlva_pkg::ROW_W-1:0] raddr;
   logic b_wr_ff;
   logic b_rd_ff;
   logic [hlva_pkg::ROW_W-1:0] b_row_ff;
   logic [hlva_pkg::CNT_W-1:0] ram_rdata;
   logic [hlva_pkg::CNT_W-1:0] inc;
   logic ram_we;
   logic [hlva_pkg::ROW_W-1:0] ram_waddr;
   logic [hlva_pkg::CNT_W-1:0] ram_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         b_wr_ff      <= 1'b0;
         b_rd_ff      <= 1'b0;
      end else begin
         tok_ff  <= tok_in;
         b_wr_ff <= vote_go;
         b_rd_ff <= rd_go;
      end
   end

   always_ff @(posedge clock) begin
      b_row_ff <= raddr;
   end

   always_comb begin
      cos_c  = hlva_pkg::cos_term(cell_idx);
      sin_c  = hlva_pkg::sin_term(cell_idx);
      prod_y = $signed({1'b0, tok_ff.y}) * cos_c;
      prod_x = $signed({1'b0, tok_ff.x}) * sin_c;
      acc    = prod_y + prod_x;
      // truncate toward zero
      rho    = 12'((acc + (acc[25] ? 26'sd16383 : 26'sd0)) >>> hlva_pkg::Q_FRAC);
      row    = $signed({rho[11], rho}) + $signed({3'b000, rho_offset});
      row_ok = !row[12] && (row[11:0] < 12'(hlva_pkg::RHO_ROWS));
      in_img = (10'(tok_ff.x) < 10'(hlva_pkg::MAX_DIM))
            && (10'(tok_ff.y) < 10'(hlva_pkg::MAX_DIM));
      vote_go = tok_ff.valid && !tok_ff.is_read && row_ok && in_img;
      rd_go   = tok_ff.valid && tok_ff.is_read && (tok_ff.angle == cell_idx)
             && ({1'b0, tok_ff.rho_idx} < 12'(hlva_pkg::RHO_ROWS));
      raddr   = tok_ff.is_read ? tok_ff.rho_idx[hlva_pkg::ROW_W-1:0]
                               : row[hlva_pkg::ROW_W-1:0];
   end

   always_comb begin
      inc       = (ram_rdata == hlva_pkg::CNT_MAX) ? ram_rdata : ram_rdata + 8'd1;
      ram_we    = clr.en || b_wr_ff;
      ram_waddr = clr.en ? clr.addr : b_row_ff;
      ram_wdata = clr.en ? '0 : inc;
   end

   hlva_ram #(
      .WIDTH (hlva_pkg::CNT_W),
      .DEPTH (hlva_pkg::RHO_ROWS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   // merge the previous cell's read into the item as it moves on
   always_comb begin
      tok_out = tok_ff;
      if (rd_in.hit) begin
         tok_out.count = rd_in.data;
         tok_out.found = 1'b1;
      end
      rd_out.hit  = b_rd_ff;
      rd_out.data = ram_rdata;
   end
endmodule

// ===== rtl/hlva_ctrl.sv =====
// Sequencer: item intake, clearing pass, register file, result register.
// Depends on hlva_pkg and hlva_if.
module hlva_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   hlva_req_if.sink                      req,
   hlva_rsp_if.source                    rsp,
   hlva_csr_if.sink                      csr,
   output hlva_pkg::tok_type             tok_head,
   input  hlva_pkg::tok_type             tok_exit,
   input  hlva_pkg::rd_type              rd_exit,
   output hlva_pkg::clr_type             clr,
   output logic [hlva_pkg::OFS_W-1:0]    rho_offset
);
   hlva_pkg::state_type state_ff, state_in;
   logic [hlva_pkg::ROW_W-1:0] clr_cnt_ff, clr_cnt_in;
   hlva_pkg::tok_type exit_ff;
   logic [hlva_pkg::CNT_W-1:0] thr_ff;
   logic [hlva_pkg::OFS_W-1:0] ofs_ff;
   logic [hlva_pkg::CNT_W-1:0] pend_count_ff, pend_count_in;
   logic pend_line_ff, pend_line_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [hlva_pkg::CNT_W-1:0] rsp_count_ff;
   logic rsp_line_ff;
   logic accept;
   logic load_rsp;
   logic clr_last;
   logic [hlva_pkg::CNT_W-1:0] exit_count;
   logic exit_found;
   hlva_pkg::opcode_type op;

   assign op       = hlva_pkg::opcode_type'(req.opcode);
   assign accept   = req.valid && req.ready;
   assign clr_last = (clr_cnt_ff == hlva_pkg::ROW_W'(hlva_pkg::RHO_ROWS - 1));
   assign csr.ready = 1'b1;
   assign rho_offset = ofs_ff;

   always_comb begin
      exit_count = rd_exit.hit ? rd_exit.data : exit_ff.count;
      exit_found = rd_exit.hit || exit_ff.found;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hlva_pkg::ST_CLEAR: begin
            if (clr_last) state_in = hlva_pkg::ST_IDLE;
         end
         hlva_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  hlva_pkg::OP_CLEAR: state_in = hlva_pkg::ST_CLEAR;
                  hlva_pkg::OP_VOTE,
                  hlva_pkg::OP_READ:  state_in = hlva_pkg::ST_RUN;
                  hlva_pkg::OP_NONE:  state_in = hlva_pkg::ST_IDLE;
               endcase
            end
         end
         hlva_pkg::ST_RUN: begin
            if (exit_ff.valid) begin
               state_in = exit_ff.is_read ? hlva_pkg::ST_DELIVER : hlva_pkg::ST_IDLE;
            end
         end
         hlva_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || rsp.ready) state_in = hlva_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req.ready     = (state_ff == hlva_pkg::ST_IDLE);
      clr.en        = (state_ff == hlva_pkg::ST_CLEAR);
      clr.addr      = clr_cnt_ff;
      clr_cnt_in    = (state_ff == hlva_pkg::ST_CLEAR) ? clr_cnt_ff + 1'b1 : '0;
      load_rsp      = (state_ff == hlva_pkg::ST_DELIVER) && (!rsp_valid_ff || rsp.ready);
      pend_count_in = pend_count_ff;
      pend_line_in  = pend_line_ff;
      if ((state_ff == hlva_pkg::ST_RUN) && exit_ff.valid) begin
         pend_count_in = exit_count;
         pend_line_in  = exit_found && (exit_count >= thr_ff);
      end
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp.ready);
      tok_head.valid   = accept && ((op == hlva_pkg::OP_VOTE) || (op == hlva_pkg::OP_READ));
      tok_head.is_read = (op == hlva_pkg::OP_READ);
      tok_head.x       = req.pixel_row;
      tok_head.y       = req.pixel_col;
      tok_head.rho_idx = req.rho_index;
      tok_head.angle   = req.angle_index;
      tok_head.count   = '0;
      tok_head.found   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hlva_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         exit_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= hlva_pkg::THRESHOLD_RST;
         ofs_ff        <= hlva_pkg::OFFSET_RST;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         exit_ff      <= tok_exit;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && (csr.index == hlva_pkg::CSR_THRESHOLD)) begin
            thr_ff <= csr.data[hlva_pkg::CNT_W-1:0];
         end
         if (csr.valid && (csr.index == hlva_pkg::CSR_OFFSET)) begin
            ofs_ff <= csr.data[hlva_pkg::OFS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_count_ff <= pend_count_in;
      pend_line_ff  <= pend_line_in;
      if (load_rsp) begin
         rsp_count_ff <= pend_count_ff;
         rsp_line_ff  <= pend_line_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.vote_count = rsp_count_ff;
   assign rsp.is_line    = rsp_line_ff;
endmodule

// ===== rtl/hough_line_vote_accumulator_top.sv =====
// channel  dir  payload                                              handshake
// req_port in   opcode, pixel_row, pixel_col, rho_index, angle_index valid/ready
// rsp_port out  vote_count, is_line                                  valid/ready
// csr_port in   index (0 threshold, 1 rho offset), data             valid/ready
// A vote or read item walks a row of 180 angle cells, one cell a cycle; no item is
// accepted until it leaves the row (and a read has passed ST_DELIVER). Each cell updates
// its own RAM. A clear item clears one row of every column per cycle, intake closed;
// the same clearing pass runs after reset. Op 3 leaves intake open. A read whose
// result finds the previous one still unaccepted holds intake until rsp_port takes it.
// Depends on hlva_pkg, hlva_if, hlva_cell, hlva_ctrl and the macros header.
`include "hough_line_vote_accumulator_top_macros.svh"
module hough_line_vote_accumulator_top (
   input  logic        clock,
   input  logic        reset,
   hlva_req_if.sink    req_port,
   hlva_rsp_if.source  rsp_port,
   hlva_csr_if.sink    csr_port
);
   hlva_pkg::tok_type link_tok [hlva_pkg::ANGLES+1];
   hlva_pkg::rd_type  link_rd  [hlva_pkg::ANGLES+1];
   hlva_pkg::clr_type clr;
   logic [hlva_pkg::OFS_W-1:0] rho_offset;

   assign link_rd[0] = '0;

   hlva_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .rsp        (rsp_port),
      .csr        (csr_port),
      .tok_head   (link_tok[0]),
      .tok_exit   (link_tok[hlva_pkg::ANGLES]),
      .rd_exit    (link_rd[hlva_pkg::ANGLES]),
      .clr        (clr),
      .rho_offset (rho_offset)
   );

   for (genvar i = 0; i < hlva_pkg::ANGLES; i++) begin : g_cell
      hlva_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (hlva_pkg::ANG_W'(i)),
         .rho_offset (rho_offset),
         .clr        (clr),
         .tok_in     (link_tok[i]),
         .rd_in      (link_rd[i]),
         .tok_out    (link_tok[i+1]),
         .rd_out     (link_rd[i+1])
      );
   end

   `HLVA_ASSERT_NOW(a_single_item, link_tok[hlva_pkg::ANGLES].valid, !link_tok[0].valid, "second item in row")
   `HLVA_ASSERT_NOW(a_clear_blocks, clr.en, !req_port.ready, "intake open during clearing pass")
   `HLVA_ASSERT_NEXT(a_busy_after_vote, link_tok[0].valid, !req_port.ready, "intake open with item in row")
endmodule
